// ----- rtl/aes256_pkg.sv -----
// Shared types, constant tables and round-function helpers for the AES-256 block.
// No dependencies; every other file of the block imports this package.
package aes256_pkg;

   localparam int KEY_REGS = 4;
   localparam int CSR_IDX_W = 2;
   localparam int RK_ROWS = 15;
   localparam int ROW_W = 4;
   localparam int LAST_STEP = 14;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_data_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_data_type;

   // A write of one row of the round-key store: enable, row index and the four words of one round key.
   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      logic [127:0]     data;
   } rk_wr_type;

   typedef logic [7:0] sbox_table_type [256];

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h00;
      p = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ p;
         p = xtime(p);
      end
      gf_mul = r;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h01;
      p = x;
      for (int i = 0; i < 8; i++) begin
         if (i != 0) r = gf_mul(r, p);
         p = gf_mul(p, p);
      end
      gf_inv = r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      rotl8 = (x << n) | (x >> (8 - n));
   endfunction

   function automatic sbox_table_type gen_sbox(input logic inverse);
      sbox_table_type t;
      logic [7:0] b;
      logic [7:0] x;
      for (int i = 0; i < 256; i++) begin
         x = 8'(i);
         if (inverse) begin
            t[i] = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
         end else begin
            b = gf_inv(x);
            t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
         end
      end
      gen_sbox = t;
   endfunction

   localparam sbox_table_type SBOX_TABLE = gen_sbox(1'b0);
   localparam sbox_table_type INV_SBOX_TABLE = gen_sbox(1'b1);

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX_TABLE[w[31:24]], SBOX_TABLE[w[23:16]],
                  SBOX_TABLE[w[15:8]], SBOX_TABLE[w[7:0]]};
   endfunction

   // Byte i of the state sits in bits 127-8i downto 120-8i; byte 4c+r is row r of column c.
   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inverse);
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         o[127-8*i -: 8] = inverse ? INV_SBOX_TABLE[s[127-8*i -: 8]]
                                   : SBOX_TABLE[s[127-8*i -: 8]];
      end
      sub_bytes = o;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inverse);
      logic [127:0] o;
      int src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inverse ? ((c + 4 - r) & 3) : ((c + r) & 3);
            o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
         end
      end
      shift_rows = o;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inverse);
      logic [127:0] o;
      logic [7:0]   a [4];
      logic [7:0]   a2, a4, a8;
      logic [7:0]   m [4][4];
      logic [7:0]   b;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k] = s[127-8*(4*c+k) -: 8];
            a2 = xtime(a[k]);
            a4 = xtime(a2);
            a8 = xtime(a4);
            // Multiples 2,3,1,1 forward and 14,11,13,9 inverse.
            m[k][0] = inverse ? (a8 ^ a4 ^ a2) : a2;
            m[k][1] = inverse ? (a8 ^ a2 ^ a[k]) : (a2 ^ a[k]);
            m[k][2] = inverse ? (a8 ^ a4 ^ a[k]) : a[k];
            m[k][3] = inverse ? (a8 ^ a[k]) : a[k];
         end
         for (int r = 0; r < 4; r++) begin
            b = 8'h00;
            for (int k = 0; k < 4; k++) b = b ^ m[k][(k - r + 4) & 3];
            o[127-8*(4*c+r) -: 8] = b;
         end
      end
      mix_columns = o;
   endfunction

endpackage

// ----- rtl/aes256_block_cipher.sv -----
// AES-256 encrypt/decrypt top level. rsp_valid is a registered strobe set by the last of
// 15 steps, one per cycle, paced by one round-key row read per cycle.
// busy stays high through the last step, so a new item is taken only once the last one is done.
// After a key register write the block is busy while it expands the key.
// Reset clears the key registers and control; round keys are undefined until a key write.
module aes256_block_cipher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  aes256_pkg::req_data_type            req_data,
   output logic                                rsp_valid,
   output aes256_pkg::rsp_data_type            rsp_data,
   input  logic                                csr_we,
   input  logic [aes256_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_wdata
);
   import aes256_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN = 1'b1;

   logic [63:0]      key_ff [KEY_REGS];
   logic             state_ff, state_in;
   logic [3:0]       step_ff, step_in;
   logic             dec_ff, dec_in;
   logic [127:0]     blk_ff, blk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff;
   logic             ks_busy;
   rk_wr_type        rk_wr;
   logic [ROW_W-1:0] rd_row;
   logic [127:0]     round_key;
   logic [127:0]     round_out;
   logic             accept;

   assign busy = (state_ff == ST_RUN) || ks_busy;
   assign accept = start && !busy;

   aes256_key_sched u_key_sched (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .key   ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .busy  (ks_busy),
      .wr    (rk_wr)
   );

   // The read is issued in the cycle before the step that uses the row.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_row = (req_data.cmd == CMD_DECRYPT) ? ROW_W'(LAST_STEP) : '0;
      end else if (dec_ff == CMD_DECRYPT) begin
         rd_row = ROW_W'(LAST_STEP - 1) - step_ff;
      end else begin
         rd_row = step_ff + 4'd1;
      end
   end

   aes256_rk_mem u_rk_mem (
      .clock   (clock),
      .wr      (rk_wr),
      .rd_row  (rd_row),
      .rd_data (round_key)
   );

   aes256_round u_round (
      .decrypt   (dec_ff),
      .first     (step_ff == 4'd0),
      .last      (step_ff == 4'(LAST_STEP)),
      .state_in  (blk_ff),
      .round_key (round_key),
      .state_out (round_out)
   );

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      dec_in = dec_ff;
      blk_in = blk_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in = 4'd0;
               dec_in = req_data.cmd;
               blk_in = {req_data.block_high, req_data.block_low};
            end
         end
         ST_RUN: begin
            blk_in = round_out;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(LAST_STEP)) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_REGS; i++) key_ff[i] <= 64'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) key_ff[csr_index] <= csr_wdata;
      end
      dec_ff <= dec_in;
      blk_ff <= blk_in;
      if (rsp_valid_in) rsp_data_ff <= {round_out[127:64], round_out[63:0]};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
endmodule

// ----- rtl/aes256_rk_mem.sv -----
// Round-key store: 15 rows of 128 bits, one write and one registered read port.
// Depends on aes256_pkg.
module aes256_rk_mem (
   input  logic                        clock,
   input  aes256_pkg::rk_wr_type       wr,
   input  logic [aes256_pkg::ROW_W-1:0] rd_row,
   output logic [127:0]                rd_data
);
   import aes256_pkg::*;

   logic [127:0] mem [RK_ROWS];
   logic [127:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.row] <= wr.data;
      rd_data_ff <= mem[rd_row];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/aes256_key_sched.sv -----
// Key expansion: produces one round-key word per cycle and writes a full row after every fourth word.
// Depends on aes256_pkg.
module aes256_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [255:0]          key,
   output logic                  busy,
   output aes256_pkg::rk_wr_type wr
);
   import aes256_pkg::*;

   logic         run_ff, run_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [7:0]   rc_ff, rc_in;
   logic [255:0] win_ff, win_in;
   logic [95:0]  acc_ff, acc_in;
   logic [31:0]  word;
   logic [31:0]  t;

   always_comb begin
      t = win_ff[31:0];
      rc_in = rc_ff;
      if (cnt_ff < 6'd8) begin
         word = key[{3'd7 - cnt_ff[2:0], 5'd0} +: 32];
      end else begin
         if (cnt_ff[2:0] == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rc_ff, 24'h0};
            rc_in = xtime(rc_ff);
         end else if (cnt_ff[2:0] == 3'd4) begin
            t = sub_word(t);
         end
         word = win_ff[255:224] ^ t;
      end
      win_in = {win_ff[223:0], word};
      acc_in = {acc_ff[63:0], word};
      cnt_in = cnt_ff + 6'd1;
      run_in = run_ff && (cnt_ff != 6'd59);
      if (start) begin
         run_in = 1'b1;
         cnt_in = 6'd0;
         rc_in = 8'h01;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= run_ff ? cnt_in : (start ? 6'd0 : cnt_ff);
      end
      if (run_ff || start) rc_ff <= rc_in;
      if (run_ff) begin
         win_ff <= win_in;
         acc_ff <= acc_in;
      end
   end

   assign busy = run_ff;
   assign wr.en = run_ff && (cnt_ff[1:0] == 2'd3);
   assign wr.row = cnt_ff[5:2];
   assign wr.data = {acc_ff, word};
endmodule

// ----- rtl/aes256_round.sv -----
// One cipher step: first key addition, a full round or the last round, either direction.
// Depends on aes256_pkg.
module aes256_round (
   input  logic         decrypt,
   input  logic         first,
   input  logic         last,
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   output logic [127:0] state_out
);
   import aes256_pkg::*;

   logic [127:0] fwd_core;
   logic [127:0] inv_core;

   always_comb begin
      fwd_core = shift_rows(sub_bytes(state_in, 1'b0), 1'b0);
      inv_core = sub_bytes(shift_rows(state_in, 1'b1), 1'b1) ^ round_key;
      if (first) begin
         state_out = state_in ^ round_key;
      end else if (decrypt) begin
         state_out = last ? inv_core : mix_columns(inv_core, 1'b1);
      end else begin
         state_out = (last ? fwd_core : mix_columns(fwd_core, 1'b0)) ^ round_key;
      end
   end
endmodule

// ----- sim/tb_aes256_block_cipher.sv -----
// Self-checking testbench for aes256_block_cipher: directed known-answer blocks, then
// random encrypt/decrypt items under several keys, checked against an in-bench AES-256 model.
// Depends on rtl/aes256_pkg.sv and rtl/aes256_block_cipher.sv.
module tb_aes256_block_cipher;
   timeunit 1ns;
   timeprecision 1ps;
   import aes256_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int KEY_IDX_0 = 0;
   localparam int KEY_IDX_3 = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_data_type req_data = '0;
   logic rsp_valid;
   rsp_data_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   aes256_block_cipher dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Cipher model state.
   logic [7:0]  fwd_sub [256];
   logic [7:0]  inv_sub [256];
   logic [63:0] key_regs [KEY_REGS];
   logic [31:0] sched [60];
   rsp_data_type blocks_due [$];

   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   int blocks_checked = 0;
   int key_writes = 0;
   int idle_pct = 0;

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [31:0] subw(input logic [31:0] w);
      return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
   endfunction

   task automatic build_sboxes();
      logic [7:0] inv;
      logic [7:0] y;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int c = 1; c < 256; c++) begin
            if (gmul(8'(x), 8'(c)) == 8'h01) inv = 8'(c);
         end
         y = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
         fwd_sub[x] = y;
         inv_sub[y] = 8'(x);
      end
   endtask

   task automatic expand_schedule();
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) begin
         sched[i] = (i % 2 == 0) ? key_regs[i/2][63:32] : key_regs[i/2][31:0];
      end
      for (int i = 8; i < 60; i++) begin
         t = sched[i-1];
         if (i % 8 == 0) begin
            t = subw({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = gmul(rcon, 8'h02);
         end else if (i % 8 == 4) begin
            t = subw(t);
         end
         sched[i] = sched[i-8] ^ t;
      end
   endtask

   // Byte i of the block sits at bits 127-8i; byte 4c+r is row r of column c.
   function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
      return s ^ {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
   endfunction

   function automatic logic [127:0] substitute(input logic [127:0] s, input logic dec);
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         o[127-8*i -: 8] = dec ? inv_sub[s[127-8*i -: 8]] : fwd_sub[s[127-8*i -: 8]];
      end
      return o;
   endfunction

   function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic dec);
      logic [127:0] o;
      int src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = dec ? (c + 4 - r) % 4 : (c + r) % 4;
            o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic dec);
      logic [127:0] o;
      logic [7:0]   coef [4];
      logic [7:0]   b;
      if (dec) begin
         coef = '{8'd14, 8'd11, 8'd13, 8'd9};
      end else begin
         coef = '{8'd2, 8'd3, 8'd1, 8'd1};
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            b = 8'h00;
            for (int k = 0; k < 4; k++) begin
               b ^= gmul(coef[(k - r + 4) % 4], s[127-8*(4*c+k) -: 8]);
            end
            o[127-8*(4*c+r) -: 8] = b;
         end
      end
      return o;
   endfunction

   function automatic rsp_data_type cipher_block(input req_data_type d);
      logic [127:0] s;
      s = {d.block_high, d.block_low};
      if (d.cmd == CMD_ENCRYPT) begin
         s = add_key(s, 0);
         for (int r = 1; r < 14; r++) begin
            s = add_key(mix(rotate_rows(substitute(s, 1'b0), 1'b0), 1'b0), r);
         end
         s = add_key(rotate_rows(substitute(s, 1'b0), 1'b0), 14);
      end else begin
         s = add_key(s, 14);
         for (int r = 13; r > 0; r--) begin
            s = mix(add_key(substitute(rotate_rows(s, 1'b1), 1'b1), r), 1'b1);
         end
         s = add_key(substitute(rotate_rows(s, 1'b1), 1'b1), 0);
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("MISMATCH %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
   endtask

   // Result checker: every strobed result must match the oldest pending block.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (blocks_due.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.result_high, 64'h0);
         end else begin
            if (rsp_data.result_high !== blocks_due[0].result_high)
               report_mismatch("result_high", rsp_data.result_high, blocks_due[0].result_high);
            if (rsp_data.result_low !== blocks_due[0].result_low)
               report_mismatch("result_low", rsp_data.result_low, blocks_due[0].result_low);
            void'(blocks_due.pop_front());
            blocks_checked++;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d blocks pending", cycles, blocks_due.size());
         $display("aes256_block_cipher regression: fail");
         $finish;
      end
   end

   task automatic wait_not_busy();
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one key register while the block is idle, then waits out the expansion.
   task automatic write_key(input int idx, input logic [63:0] value);
      while (blocks_due.size() != 0) @(posedge clock);
      repeat (20) @(negedge clock);
      wait_not_busy();
      csr_we <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      key_regs[idx] = value;
      expand_schedule();
      key_writes++;
      repeat (2) @(negedge clock);
      wait_not_busy();
   endtask

   task automatic load_key(input logic [255:0] k);
      for (int i = KEY_IDX_0; i <= KEY_IDX_3; i++) write_key(i, k[255-64*i -: 64]);
   endtask

   // Presents one item from a falling edge and holds it until it is taken.
   task automatic send_block(input req_data_type d, input logic known,
                             input rsp_data_type want);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(20, 1)) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      blocks_due.push_back(known ? want : cipher_block(d));
      items_sent++;
      @(negedge clock);
   endtask

   typedef struct {
      req_data_type d;
      logic         known;
      rsp_data_type want;
   } vector_row_type;

   vector_row_type vectors [] = '{
      '{'{CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff}, 1'b1,
        '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}},
      '{'{CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089}, 1'b1,
        '{64'h0011223344556677, 64'h8899aabbccddeeff}},
      '{'{CMD_ENCRYPT, 64'h0, 64'h0}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_DECRYPT, 64'h0, 64'h0}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_ENCRYPT, '1, '1}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_DECRYPT, '1, '1}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_ENCRYPT, 64'h8000000000000000, 64'h1}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_DECRYPT, 64'h1, 64'h8000000000000000}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_ENCRYPT, '1, 64'h0}, 1'b0, '{64'h0, 64'h0}},
      '{'{CMD_DECRYPT, 64'h0, '1}, 1'b0, '{64'h0, 64'h0}}
   };

   initial begin
      req_data_type d;
      logic [255:0] k;
      int sel;
      build_sboxes();
      for (int i = 0; i < KEY_REGS; i++) key_regs[i] = 64'h0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
      foreach (vectors[i]) send_block(vectors[i].d, vectors[i].known, vectors[i].want);
      start <= 1'b0;

      for (int phase = 0; phase < 10; phase++) begin
         idle_pct = (phase < 4) ? 27 : (phase < 7) ? 73 : 0;
         case (phase)
            0: load_key('0);
            1: load_key('1);
            4: write_key($urandom_range(KEY_IDX_3), {$urandom, $urandom});
            default: begin
               for (int w = 0; w < 8; w++) k[32*w +: 32] = $urandom;
               load_key(k);
            end
         endcase
         for (int n = 0; n < 100; n++) begin
            d.cmd = $urandom_range(1);
            d.block_high = {$urandom, $urandom};
            d.block_low = {$urandom, $urandom};
            sel = $urandom_range(15);
            if (sel == 0) d.block_high = '0;
            if (sel == 1) d.block_low = '1;
            // Round trips: decrypting a fresh ciphertext must give back the plaintext.
            if (sel >= 12) begin
               d.cmd = CMD_ENCRYPT;
               send_block(d, 1'b0, '0);
               d = '{CMD_DECRYPT, blocks_due[$].result_high, blocks_due[$].result_low};
            end
            send_block(d, 1'b0, '0);
            // Occasionally drop start so idle also lands right after acceptance.
            if (idle_pct != 0 && $urandom_range(9) == 0) begin
               start <= 1'b0;
               @(negedge clock);
            end
         end
         start <= 1'b0;
      end

      while (blocks_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d key register writes; %0d results checked.",
               items_sent, key_writes, blocks_checked);
      $display("Keys covered all-zero, all-one, random and single-register updates.");
      if (errors == 0) begin
         $display("aes256_block_cipher regression: pass");
      end else begin
         $display("aes256_block_cipher regression: fail");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/aes256_pkg.sv
rtl/aes256_rk_mem.sv
rtl/aes256_key_sched.sv
rtl/aes256_round.sv
rtl/aes256_block_cipher.sv
sim/tb_aes256_block_cipher.sv
